// ===== rtl/date_to_time_step_index_defines.svh =====
// Assertion macros shared by the date to time-step index RTL.
// Included by the top level; no other dependencies.
`ifndef DATE_TO_TIME_STEP_INDEX_DEFINES_SVH
`define DATE_TO_TIME_STEP_INDEX_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define DTSI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dtsi same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define DTSI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dtsi next-cycle check failed");

`endif

// ===== rtl/dtsi_pkg.sv =====
// Package for the date to time-step index block: widths, mode codes,
// calendar constants and the days-before-month table. No dependencies.
`default_nettype none

package dtsi_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned IDX_W   = 22;

	// Step mode codes; the fourth code means unknown and yields zero
	localparam logic [1:0] MODE_YEAR  = 2'd0;
	localparam logic [1:0] MODE_MONTH = 2'd1;
	localparam logic [1:0] MODE_DAY   = 2'd2;

	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
	localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
	// ceil(2^16 / 25): exact quotient by 25 for 12-bit dividends
	localparam logic [11:0] RECIP25 = 12'd2622;
	localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

	// Days of all months before the given month; month zero counts none,
	// months past December count the whole year
	function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [8:0] d;
		case (m)
			4'd0, 4'd1: d = 9'd0;
			4'd2:       d = 9'd31;
			4'd3:       d = 9'd59;
			4'd4:       d = 9'd90;
			4'd5:       d = 9'd120;
			4'd6:       d = 9'd151;
			4'd7:       d = 9'd181;
			4'd8:       d = 9'd212;
			4'd9:       d = 9'd243;
			4'd10:      d = 9'd273;
			4'd11:      d = 9'd304;
			4'd12:      d = 9'd334;
			default:    d = 9'd365;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dtsi_day_count.sv =====
// Proleptic Gregorian day count (0001-01-01 is 1), clipped to the index width.
// Pure combinational; depends on dtsi_pkg.
`default_nettype none

module dtsi_day_count (
	input  wire logic [dtsi_pkg::DAY_W-1:0]   day,
	input  wire logic [dtsi_pkg::MONTH_W-1:0] month,
	input  wire logic [dtsi_pkg::YEAR_W-1:0]  year,
	output logic      [dtsi_pkg::IDX_W-1:0]   count
);
	import dtsi_pkg::*;

	logic [YEAR_W-1:0] prev_year;
	logic [11:0]       prev_q4;
	logic [23:0]       prev_prod;
	logic [7:0]        prev_q100;
	logic [5:0]        prev_q400;
	logic [22:0]       prev_days;
	logic [22:0]       base;
	logic [11:0]       cur_q4;
	logic [23:0]       cur_prod;
	logic              div4;
	logic              div100;
	logic              div400;
	logic              leap_add;
	logic [24:0]       total;

	// Leap days in whole years before this one: p/4 - p/100 + p/400,
	// with p/100 taken as (p/4)/25 through a reciprocal multiply
	assign prev_year = year - YEAR_W'(1);
	assign prev_q4   = prev_year[YEAR_W-1:2];
	assign prev_prod = 24'(prev_q4) * 24'(RECIP25);
	assign prev_q100 = prev_prod[23:16];
	assign prev_q400 = prev_q100[7:2];
	assign prev_days = 23'(prev_year) * 23'(DAYS_PER_YEAR);
	assign base = prev_days + 23'(prev_q4) - 23'(prev_q100) + 23'(prev_q400);

	// Leap test of this year: (y/4) is a multiple of 25 exactly when the
	// fraction of the reciprocal product stays below the reciprocal
	assign cur_q4   = year[YEAR_W-1:2];
	assign cur_prod = 24'(cur_q4) * 24'(RECIP25);
	assign div4     = (year[1:0] == 2'b00);
	assign div100   = div4 && (cur_prod[15:0] < 16'(RECIP25));
	assign div400   = div100 && (cur_prod[17:16] == 2'b00);
	assign leap_add = ((div4 && !div100) || div400) && (month > MONTH_W'(2));

	// Year zero counts minus one year; the sum is two's complement
	always_comb begin
		if (year == '0) begin
			total = 25'd0 - 25'(DAYS_PER_YEAR);
		end else begin
			total = 25'(base);
		end
		total = total + 25'(days_before_month(month)) + 25'(day) + 25'(leap_add);
	end

	// Clip below at zero and above at the largest index
	always_comb begin
		if (total[24]) begin
			count = '0;
		end else if (total[23:22] != 2'b00) begin
			count = IDX_MAX;
		end else begin
			count = total[IDX_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/date_to_time_step_index.sv =====
// Date to time-step index converter. Takes one date word per cycle into an
// input register, converts it in a single combinational pass and holds the
// index in an output register, one word per cycle sustained while out_stall is
// low. The output register lets a new word enter while a result waits;
// in_stall rises only when both registers hold words and out_stall is high.
// Mode 0 gives the year, mode 1 year*12+month, mode 2 the Gregorian day
// count (0001-01-01 is 1, clipped to 0..4194303), mode 3 zero.
// Depends on dtsi_pkg, dtsi_day_count and the defines header.
`default_nettype none

`include "date_to_time_step_index_defines.svh"

module date_to_time_step_index (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     mode,
	input  wire logic [dtsi_pkg::DAY_W-1:0]     day,
	input  wire logic [dtsi_pkg::MONTH_W-1:0]   month,
	input  wire logic [dtsi_pkg::YEAR_W-1:0]    year,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [dtsi_pkg::IDX_W-1:0]     step_index
);
	import dtsi_pkg::*;

	logic                 valid_s1;
	logic [1:0]           mode_s1;
	logic [DAY_W-1:0]     day_s1;
	logic [MONTH_W-1:0]   month_s1;
	logic [YEAR_W-1:0]    year_s1;
	logic                 valid_s2;
	logic [IDX_W-1:0]     index_s2;
	logic                 s2_ready;
	logic                 s1_ready;
	logic [IDX_W-1:0]     day_idx;
	logic [IDX_W-1:0]     index_nxt;
	logic                 year_load;

	// Handshake: each register advances when its successor has room
	assign s2_ready = !valid_s2 || !out_stall;
	assign s1_ready = !valid_s1 || s2_ready;
	assign in_stall = !s1_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && in_valid) begin
			mode_s1  <= mode;
			day_s1   <= day;
			month_s1 <= month;
			year_s1  <= year;
		end
	end

	dtsi_day_count u_day_count (
		.day   (day_s1),
		.month (month_s1),
		.year  (year_s1),
		.count (day_idx)
	);

	// Index select by mode
	always_comb begin
		unique case (mode_s1)
			MODE_YEAR:  index_nxt = IDX_W'(year_s1);
			MODE_MONTH: index_nxt = IDX_W'(year_s1) * IDX_W'(MONTHS_PER_YEAR)
				+ IDX_W'(month_s1);
			MODE_DAY:   index_nxt = day_idx;
			default:    index_nxt = '0;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			index_s2 <= index_nxt;
		end
	end

	assign out_valid  = valid_s2;
	assign step_index = index_s2;

	// Checks
	assign year_load = valid_s1 && s2_ready && (mode_s1 == MODE_YEAR);

	`DTSI_ASSERT_IMP(a_stall_when_full, clk, arst_n, in_stall, valid_s1 && valid_s2 && out_stall)
	`DTSI_ASSERT_NXT(a_word_moves_to_output, clk, arst_n, (valid_s1 && s2_ready), out_valid)
	`DTSI_ASSERT_NXT(a_year_passes, clk, arst_n, year_load, step_index == IDX_W'($past(year_s1)))

endmodule

`default_nettype wire
